### hdl/pvs_pkg.sv
// Package for the periodic ventilation scheduler: payload structs, phase and
// fan command codes, register indexes and sizing constants. No dependencies.
package pvs_pkg;

   // Number of higher-priority fan modes that can hold off the schedule.
   localparam int NUM_OTHER_MODES = 5;

   localparam int BUSY_WIDTH   = 5;
   localparam int MINUTE_WIDTH = 16;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;

   // Only the low NUM_OTHER_MODES bits of the busy field are looked at.
   localparam logic [BUSY_WIDTH-1:0] BUSY_MASK =
      BUSY_WIDTH'((64'd1 << NUM_OTHER_MODES) - 64'd1);

   localparam logic [MINUTE_WIDTH-1:0] INTERVAL_RESET = 16'd60;
   localparam logic [MINUTE_WIDTH-1:0] RUN_RESET      = 16'd10;

   typedef enum logic [1:0] {
      PH_IDLE        = 2'd0,
      PH_COUNTDOWN   = 2'd1,
      PH_VENTILATING = 2'd2,
      PH_INTERRUPTED = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_ON   = 2'd1,
      CMD_OFF  = 2'd2
   } fan_cmd_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_INTERVAL = 2'd0,
      CSR_RUN      = 2'd1,
      CSR_ENABLE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BUSY_WIDTH-1:0] busy_modes;
      logic                  minute_passed;
   } req_payload_type;

   typedef struct packed {
      fan_cmd_type             fan_command;
      phase_type               phase_now;
      logic [MINUTE_WIDTH-1:0] minutes_remaining;
   } rsp_payload_type;

endpackage

### hdl/periodic_ventilation_scheduler_unit.sv
// Periodic ventilation scheduler: phase state machine, minute counter and a
// two-entry result queue. Depends on pvs_pkg.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------
//   req      | in        | req_valid / req_stall | busy_modes, minute_passed
//   rsp      | out       | rsp_valid / rsp_stall | fan_command, phase_now,
//            |           |                       | minutes_remaining
//   csr      | in        | csr_write_en          | csr_index, csr_wdata
//
// Every poll is handled as it is transferred: the next phase and count are
// computed combinationally from the state registers and the request, and the
// result is written into a two-entry output queue. One poll can be accepted
// per clock; req_stall rises only when both queue entries hold results.
// The first result is visible in the cycle after its poll is transferred.
// Reset is synchronous and active high. It returns the phase to idle, clears
// the count, empties the queue and loads the register defaults (interval 60,
// run 10, schedule disabled).
module periodic_ventilation_scheduler_unit (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pvs_pkg::req_payload_type              req_data,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pvs_pkg::rsp_payload_type              rsp_data,

   input  logic                                  csr_write_en,
   input  logic [pvs_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [pvs_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   // Configuration registers.
   logic [pvs_pkg::MINUTE_WIDTH-1:0] interval_ff;
   logic [pvs_pkg::MINUTE_WIDTH-1:0] run_ff;
   logic                             enable_ff;

   // Scheduler state.
   pvs_pkg::phase_type               phase_ff, phase_in;
   logic [pvs_pkg::MINUTE_WIDTH-1:0] minutes_ff, minutes_in;
   pvs_pkg::fan_cmd_type             cmd;

   // Result queue: slot 0 is the head that drives the rsp channel.
   pvs_pkg::rsp_payload_type         slot0_ff, slot1_ff;
   logic [1:0]                       count_ff;

   logic push;
   logic pop;
   logic fill_head;
   logic schedule_live;
   logic any_mode_busy;
   pvs_pkg::rsp_payload_type result;

   assign req_stall = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign push      = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   // Register writes. An index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= pvs_pkg::INTERVAL_RESET;
         run_ff      <= pvs_pkg::RUN_RESET;
         enable_ff   <= 1'b0;
      end else if (csr_write_en) begin
         unique case (pvs_pkg::csr_index_type'(csr_index))
            pvs_pkg::CSR_INTERVAL: interval_ff <= csr_wdata;
            pvs_pkg::CSR_RUN:      run_ff      <= csr_wdata;
            pvs_pkg::CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign schedule_live = enable_ff && (interval_ff != '0) && (run_ff != '0);
   assign any_mode_busy = (req_data.busy_modes & pvs_pkg::BUSY_MASK) != '0;

   // Next phase and count for one poll. The minute tick is applied first,
   // then the poll itself decides between idle, countdown and interruption.
   always_comb begin
      phase_in   = phase_ff;
      minutes_in = minutes_ff;
      cmd        = pvs_pkg::CMD_NONE;

      if (req_data.minute_passed &&
          (phase_ff == pvs_pkg::PH_COUNTDOWN || phase_ff == pvs_pkg::PH_VENTILATING)) begin
         if (minutes_ff > 16'd1) begin
            minutes_in = minutes_ff - 16'd1;
         end else if (phase_ff == pvs_pkg::PH_COUNTDOWN) begin
            // Countdown over: start the scheduled run.
            phase_in   = pvs_pkg::PH_VENTILATING;
            minutes_in = run_ff;
            cmd        = pvs_pkg::CMD_ON;
         end else begin
            // Run over: fan off and wait another interval.
            phase_in   = pvs_pkg::PH_COUNTDOWN;
            minutes_in = interval_ff;
            cmd        = pvs_pkg::CMD_OFF;
         end
      end

      if (!schedule_live) begin
         if (phase_in == pvs_pkg::PH_VENTILATING) begin
            cmd = pvs_pkg::CMD_OFF;
         end
         phase_in   = pvs_pkg::PH_IDLE;
         minutes_in = '0;
      end else begin
         unique case (phase_in)
            pvs_pkg::PH_IDLE, pvs_pkg::PH_INTERRUPTED: begin
               if (!any_mode_busy) begin
                  phase_in   = pvs_pkg::PH_COUNTDOWN;
                  minutes_in = interval_ff;
               end
            end
            pvs_pkg::PH_COUNTDOWN: begin
               if (any_mode_busy) begin
                  phase_in   = pvs_pkg::PH_INTERRUPTED;
                  minutes_in = '0;
               end
            end
            default: ;  // a run is not affected by busy modes
         endcase
      end

      result.fan_command       = cmd;
      result.phase_now         = phase_in;
      result.minutes_remaining = minutes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pvs_pkg::PH_IDLE;
         minutes_ff <= '0;
      end else if (push) begin
         phase_ff   <= phase_in;
         minutes_ff <= minutes_in;
      end
   end

   // Queue occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (push && !pop) begin
         count_ff <= count_ff + 2'd1;
      end else if (pop && !push) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   // Queue payload. The head advances on every transfer out; a new result
   // lands in the first slot that is free after that move.
   assign fill_head = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);

   always_ff @(posedge clock) begin
      if (push && fill_head) begin
         slot0_ff <= result;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
      if (push && !fill_head) begin
         slot1_ff <= result;
      end
   end

   // A result that turns the fan on always reports a running ventilation.
   a_on_means_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fan_command == pvs_pkg::CMD_ON |->
         rsp_data.phase_now == pvs_pkg::PH_VENTILATING)
      else $error("fan-on result outside the ventilating phase");

   // Idle and interrupted phases never carry a count.
   a_quiet_count_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pvs_pkg::PH_IDLE || phase_ff == pvs_pkg::PH_INTERRUPTED |->
         minutes_ff == '0)
      else $error("count held while idle or interrupted");

   // After a transferred poll the rsp channel holds a valid result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid)
      else $error("accepted poll produced no result");

   // The queue never claims more than its two entries.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue overflow");

endmodule

### dv/periodic_ventilation_scheduler_unit_test.sv
// Self-checking testbench for periodic_ventilation_scheduler_unit: directed and
// random polls, register settings applied between phases, and a predictor in a
// small scoreboard class. Depends on pvs_pkg and the unit itself.
module periodic_ventilation_scheduler_unit_test;

   typedef logic [pvs_pkg::BUSY_WIDTH-1:0] busy_type;

   // The index that no register uses; a write to it must change nothing.
   localparam logic [pvs_pkg::CSR_IDX_WIDTH-1:0] CSR_SPARE = 2'd3;

   // Cycles without any transfer before the run is declared hung.
   localparam int QUIET_LIMIT = 1000;

   localparam int RANDOM_PHASES   = 12;
   localparam int POLLS_PER_PHASE = 155;

   // Scoreboard: tracks the scheduler state and register values, works out the
   // result of every transferred poll and checks results in order.
   class schedule_tracker;
      pvs_pkg::phase_type                phase;
      logic [pvs_pkg::MINUTE_WIDTH-1:0]  minutes_left;
      logic [pvs_pkg::MINUTE_WIDTH-1:0]  interval;
      logic [pvs_pkg::MINUTE_WIDTH-1:0]  run;
      logic                              enabled;
      pvs_pkg::rsp_payload_type          poll_outcomes[$];
      int                                failures;

      function new();
         phase        = pvs_pkg::PH_IDLE;
         minutes_left = '0;
         interval     = pvs_pkg::INTERVAL_RESET;
         run          = pvs_pkg::RUN_RESET;
         enabled      = 1'b0;
         failures     = 0;
      endfunction

      function void write_reg(logic [pvs_pkg::CSR_IDX_WIDTH-1:0] idx,
                              logic [pvs_pkg::CSR_DATA_WIDTH-1:0] data);
         case (idx)
            pvs_pkg::CSR_INTERVAL: interval = data;
            pvs_pkg::CSR_RUN:      run      = data;
            pvs_pkg::CSR_ENABLE:   enabled  = data[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return poll_outcomes.size();
      endfunction

      function void note_poll(pvs_pkg::req_payload_type item);
         busy_type                 busy;
         logic                     any_mode_busy;
         pvs_pkg::fan_cmd_type     cmd;
         pvs_pkg::rsp_payload_type outcome;
         busy          = item.busy_modes & pvs_pkg::BUSY_MASK;
         any_mode_busy = |busy;
         cmd           = pvs_pkg::CMD_NONE;

         // The minute tick is applied before the poll is looked at.
         if (item.minute_passed &&
             (phase == pvs_pkg::PH_COUNTDOWN || phase == pvs_pkg::PH_VENTILATING)) begin
            if (minutes_left > 16'd1) begin
               minutes_left = minutes_left - 16'd1;
            end else if (phase == pvs_pkg::PH_COUNTDOWN) begin
               phase        = pvs_pkg::PH_VENTILATING;
               minutes_left = run;
               cmd          = pvs_pkg::CMD_ON;
            end else begin
               phase        = pvs_pkg::PH_COUNTDOWN;
               minutes_left = interval;
               cmd          = pvs_pkg::CMD_OFF;
            end
         end

         if (!enabled || interval == '0 || run == '0) begin
            if (phase == pvs_pkg::PH_VENTILATING) begin
               cmd = pvs_pkg::CMD_OFF;
            end
            phase        = pvs_pkg::PH_IDLE;
            minutes_left = '0;
         end else if (phase == pvs_pkg::PH_IDLE || phase == pvs_pkg::PH_INTERRUPTED) begin
            if (!any_mode_busy) begin
               phase        = pvs_pkg::PH_COUNTDOWN;
               minutes_left = interval;
            end
         end else if (phase == pvs_pkg::PH_COUNTDOWN) begin
            if (any_mode_busy) begin
               phase        = pvs_pkg::PH_INTERRUPTED;
               minutes_left = '0;
            end
         end

         outcome.fan_command       = cmd;
         outcome.phase_now         = phase;
         outcome.minutes_remaining = minutes_left;
         poll_outcomes.push_back(outcome);
      endfunction

      function void check_result(pvs_pkg::rsp_payload_type got);
         pvs_pkg::rsp_payload_type want;
         if (poll_outcomes.size() == 0) begin
            $error("result transferred with no poll outstanding");
            failures++;
            return;
         end
         want = poll_outcomes.pop_front();
         if (got.fan_command !== want.fan_command) begin
            $error("fan_command: expected %0d, got %0d", want.fan_command, got.fan_command);
            failures++;
         end
         if (got.phase_now !== want.phase_now) begin
            $error("phase_now: expected %0d, got %0d", want.phase_now, got.phase_now);
            failures++;
         end
         if (got.minutes_remaining !== want.minutes_remaining) begin
            $error("minutes_remaining: expected %0d, got %0d",
                   want.minutes_remaining, got.minutes_remaining);
            failures++;
         end
      endfunction
   endclass

   // Every input of the unit holds a known value from time zero.
   logic                               clock        = 1'b0;
   logic                               reset        = 1'b1;
   logic                               req_valid    = 1'b0;
   logic                               req_stall;
   pvs_pkg::req_payload_type           req_data     = '0;
   logic                               rsp_valid;
   logic                               rsp_stall    = 1'b0;
   pvs_pkg::rsp_payload_type           rsp_data;
   logic                               csr_write_en = 1'b0;
   logic [pvs_pkg::CSR_IDX_WIDTH-1:0]  csr_index    = '0;
   logic [pvs_pkg::CSR_DATA_WIDTH-1:0] csr_wdata    = '0;

   schedule_tracker tracker;
   int  polls_accepted = 0;
   int  quiet_cycles   = 0;
   // When low, neither side inserts gaps or stalls.
   logic idling_on = 1'b1;

   periodic_ventilation_scheduler_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // The result side stalls at random, with a chance of 17 in a hundred while
   // idling_on is high. Stalls are changed at the falling edge so they are stable at the rising edge.
   always @(negedge clock) begin
      rsp_stall <= idling_on && ($urandom_range(99) < 17);
   end

   // Monitor: everything is sampled at the rising edge, where the values seen
   // are the ones driven at the falling edge before it. Register writes are mirrored
   // into the tracker at the same edge at which the unit takes them.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en) begin
            tracker.write_reg(csr_index, csr_wdata);
         end
         if (req_valid && !req_stall) begin
            tracker.note_poll(req_data);
            polls_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_result(rsp_data);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("periodic_ventilation_scheduler_unit_test: done, errors");
      $finish;
   end

   // Offers one poll and returns, at a falling edge, once it has been
   // transferred. Valid stays high from one poll into the next unless a gap is
   // chosen, so it is never lowered and raised within one time step.
   task automatic send_poll(input busy_type busy, input logic tick);
      int target;
      while (idling_on && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data.busy_modes    <= busy;
      req_data.minute_passed <= tick;
      req_valid              <= 1'b1;
      target = polls_accepted + 1;
      do begin
         @(negedge clock);
      end while (polls_accepted < target);
   endtask

   // Holds off the sender until every expected result has been transferred,
   // then lets the two-entry output queue settle before it returns.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   // One register write per cycle; the caller lowers the enable afterwards.
   task automatic write_csr(input logic [pvs_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [pvs_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
   endtask

   // Writes all three registers once the unit is quiet. The enable register
   // carries random upper bits, which the unit must ignore.
   task automatic set_schedule(input logic [pvs_pkg::MINUTE_WIDTH-1:0] interval,
                               input logic [pvs_pkg::MINUTE_WIDTH-1:0] run,
                               input logic en);
      drain();
      write_csr(pvs_pkg::CSR_INTERVAL, interval);
      write_csr(pvs_pkg::CSR_RUN, run);
      write_csr(pvs_pkg::CSR_ENABLE, {15'($urandom), en});
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Random poll content. Most polls see no busy mode so that the countdown
   // and the run actually complete; the rest hold one busy mode or any mix.
   task automatic send_random_poll();
      int       pick;
      busy_type busy;
      pick = $urandom_range(99);
      if (pick < 78) begin
         busy = '0;
      end else if (pick < 90) begin
         busy = busy_type'(1) << $urandom_range(pvs_pkg::BUSY_WIDTH - 1);
      end else begin
         busy = busy_type'($urandom);
      end
      send_poll(busy, 1'($urandom));
   endtask

   initial begin
      logic [pvs_pkg::MINUTE_WIDTH-1:0] interval;
      logic [pvs_pkg::MINUTE_WIDTH-1:0] run;
      logic                             en;
      tracker = new();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. With the reset settings the schedule is disabled, so
      // every poll, ticking or busy, stays idle.
      send_poll(5'b11111, 1'b1);
      send_poll(5'b00000, 1'b0);

      // One-minute interval and run: start, interruption by busy modes, a tick
      // ignored while interrupted, fan on, busy modes ignored while
      // ventilating, and the run ending into an interrupted countdown.
      set_schedule(16'd1, 16'd1, 1'b1);
      send_poll(5'b00000, 1'b0);
      send_poll(5'b10101, 1'b0);
      send_poll(5'b00000, 1'b1);
      send_poll(5'b00000, 1'b1);
      send_poll(5'b11111, 1'b0);
      send_poll(5'b11111, 1'b1);
      send_poll(5'b01010, 1'b1);
      send_poll(5'b00000, 1'b0);
      send_poll(5'b00000, 1'b1);

      // The run ends in the same poll in which the schedule is seen disabled:
      // the block goes idle with the fan-off command.
      set_schedule(16'd1, 16'd1, 1'b0);
      send_poll(5'b00000, 1'b1);

      // Disabling in the middle of a run switches the fan off.
      set_schedule(16'd2, 16'd2, 1'b1);
      send_poll(5'b00000, 1'b0);
      send_poll(5'b00000, 1'b1);
      send_poll(5'b00000, 1'b1);
      set_schedule(16'd2, 16'd2, 1'b0);
      send_poll(5'b00000, 1'b0);

      // A zero interval or a zero run keeps the enabled schedule idle.
      set_schedule(16'd0, 16'd3, 1'b1);
      send_poll(5'b00000, 1'b1);
      set_schedule(16'd3, 16'd0, 1'b1);
      send_poll(5'b00000, 1'b0);

      // Largest times, and a write to the unused index that must change nothing.
      set_schedule(16'hFFFF, 16'hFFFF, 1'b1);
      write_csr(CSR_SPARE, 16'($urandom));
      csr_write_en <= 1'b0;
      @(negedge clock);
      send_poll(5'b00000, 1'b1);
      send_poll(5'b00000, 1'b1);

      // Random part: each phase starts from its own settings, mostly short
      // times so that many countdowns and runs complete.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         interval = 16'($urandom_range(1, 6));
         run      = 16'($urandom_range(1, 6));
         en       = 1'b1;
         idling_on = 1'b1;
         case (ph)
            1: begin
               interval = 16'd1;
               run      = 16'd1;
            end
            2: begin
               interval = 16'hFFFF;
               run      = 16'd1;
            end
            3: idling_on = 1'b0;   // a long stretch with no gaps or stalls
            4: interval = 16'd0;
            5: run = 16'd0;
            6: begin
               interval = 16'd1;
               run      = 16'hFFFF;
            end
            7: en = 1'($urandom);
            default: ;
         endcase
         set_schedule(interval, run, en);
         for (int i = 0; i < POLLS_PER_PHASE; i++) begin
            // Halfway through a phase the sender waits for every result. In
            // odd phases one register then changes while a countdown or a run
            // may be under way.
            if (i == POLLS_PER_PHASE / 2) begin
               drain();
               if (ph % 2 == 1) begin
                  case ($urandom_range(2))
                     0: write_csr(pvs_pkg::CSR_INTERVAL, 16'($urandom_range(0, 5)));
                     1: write_csr(pvs_pkg::CSR_RUN, 16'($urandom_range(0, 5)));
                     default: write_csr(pvs_pkg::CSR_ENABLE, 16'($urandom));
                  endcase
                  csr_write_en <= 1'b0;
                  @(negedge clock);
               end
            end
            send_random_poll();
         end
      end

      // Wait for the last results and give the unit time to show any extra one.
      idling_on = 1'b1;
      drain();
      repeat (10) @(negedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("periodic_ventilation_scheduler_unit_test: done, clean");
      end else begin
         $display("periodic_ventilation_scheduler_unit_test: done, errors");
      end
      $finish;
   end

endmodule
